// File: hw/rtl/nearest_k_slot_assigner_macros.svh
// ----------------------------------------------------------------------------
// nearest_k_slot_assigner_macros.svh
// Assertion macros used by the port-level checker of the slot assigner.
// ----------------------------------------------------------------------------
`ifndef NEAREST_K_SLOT_ASSIGNER_MACROS_SVH
`define NEAREST_K_SLOT_ASSIGNER_MACROS_SVH

// Same-cycle implication, clocked on aclk, masked during reset
`define NKSA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nksa assertion failed");

// Next-cycle implication, clocked on aclk, masked during reset
`define NKSA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nksa assertion failed");

`endif

// File: hw/rtl/nksa_pkg.sv
// ----------------------------------------------------------------------------
// nksa_pkg
// Constants, codes and controller/datapath interface types of the
// nearest-K slot assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package nksa_pkg;

    // Sizing
    localparam int MAX_LIGHTS   = 16;
    localparam int SLOTS        = 4;
    localparam int RESULT_LIMIT = 16;
    localparam int EMIT_MAX     = (MAX_LIGHTS < RESULT_LIMIT) ? MAX_LIGHTS : RESULT_LIMIT;
    localparam int IDX_W        = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CNT_W        = $clog2(MAX_LIGHTS + 1);

    // Field widths
    localparam int COORD_W  = 16;
    localparam int ABS_W    = 16;
    localparam int SQ_W     = 2 * ABS_W;
    localparam int DIST_W   = SQ_W + 2;
    localparam int INDEX_W  = 4;
    localparam int SLOT_W   = 3;
    localparam int IN_W     = 3 * COORD_W;
    localparam int OUT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Slot code for "no slot"
    localparam logic [SLOT_W-1:0] SLOT_NONE = 3'b111;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_EN = 2'd3;

    // Axis select for the shared multiplier
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_item;
        logic       square;
        logic [1:0] axis;
        logic       insert;
        logic       set_ovf;
        logic       emit_load;
        logic       clear_batch;
    } nksa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic emit_last;
        logic out_free;
    } nksa_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/nksa_ctrl.sv
// ----------------------------------------------------------------------------
// nksa_ctrl
// Sequencer: accepts a point, steps the shared multiplier over three axes,
// inserts the distance into the rank cells and drives the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module nksa_ctrl
    import nksa_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    input  wire logic         in_last,
    output logic              in_ready,
    input  wire nksa_status_t status,
    output nksa_cmd_t         cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_INSERT = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       last_reg, last_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    last_next     = in_last;
                    if (status.full) begin
                        // dropped point, its batch end still closes the batch
                        cmd.set_ovf = 1'b1;
                        state_next  = in_last ? ST_EMIT : ST_IDLE;
                    end else begin
                        state_next = ST_SQUARE;
                        axis_next  = AXIS_X;
                    end
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                if (axis_reg == AXIS_Z) begin
                    state_next = ST_INSERT;
                end else begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                state_next = last_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        cmd.clear_batch = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            axis_reg  <= AXIS_X;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/nksa_datapath.sv
// ----------------------------------------------------------------------------
// nksa_datapath
// Viewer registers, axis differences, shared squaring multiplier, a row of
// rank cells holding distance and running rank, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nksa_datapath
    import nksa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire nksa_cmd_t             cmd,
    output nksa_status_t               status,
    input  wire logic [IN_W-1:0]       in_data,
    input  wire logic                  cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    // |p - v| of two signed coordinates, exact in 16 unsigned bits
    function automatic logic [ABS_W-1:0] abs_diff(input logic [COORD_W-1:0] p,
                                                  input logic [COORD_W-1:0] v);
        logic [COORD_W:0] d;
        logic [COORD_W:0] n;
        begin
            d = {p[COORD_W-1], p} - {v[COORD_W-1], v};
            n = -d;
            return d[COORD_W] ? n[ABS_W-1:0] : d[ABS_W-1:0];
        end
    endfunction

    // Configuration
    logic [COORD_W-1:0] vx_reg, vy_reg, vz_reg;
    logic               en_reg;

    // Per-item working registers
    logic [ABS_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic [DIST_W-1:0] acc_reg;

    // Rank cells
    logic [DIST_W-1:0] dist_reg [MAX_LIGHTS];
    logic [IDX_W-1:0]  rank_reg [MAX_LIGHTS];
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic [IDX_W-1:0]  emit_idx_reg;

    // Output register
    logic               m_valid_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic [SLOT_W-1:0]  m_slot_reg;
    logic               m_ovf_reg;
    logic               m_last_reg;

    logic [ABS_W-1:0]   sq_sel;
    logic [SQ_W-1:0]    sq;
    logic [DIST_W-1:0]  acc_next;
    logic [MAX_LIGHTS-1:0] cell_valid;
    logic [MAX_LIGHTS-1:0] cell_less;
    logic [IDX_W-1:0]   new_rank;
    logic [IDX_W-1:0]   wr_idx;
    logic [CNT_W-1:0]   emit_cnt;
    logic               emit_last;
    logic [IDX_W-1:0]   rank_sel;
    logic [SLOT_W-1:0]  slot_sel;

    // Shared squaring unit and accumulator
    always_comb begin
        case (cmd.axis)
            AXIS_X:  sq_sel = dx_reg;
            AXIS_Y:  sq_sel = dy_reg;
            default: sq_sel = dz_reg;
        endcase
        sq       = sq_sel * sq_sel;
        acc_next = ((cmd.axis == AXIS_X) ? '0 : acc_reg) + DIST_W'(sq);
    end

    // Each cell compares the new distance with its own; ties rank the older
    always_comb begin
        new_rank = '0;
        for (int k = 0; k < MAX_LIGHTS; k++) begin
            cell_valid[k] = (CNT_W'(k) < count_reg);
            cell_less[k]  = (acc_reg < dist_reg[k]);
            if (cell_valid[k] && !cell_less[k]) begin
                new_rank = new_rank + IDX_W'(1);
            end
        end
    end

    assign wr_idx = count_reg[IDX_W-1:0];

    // Emission bookkeeping
    assign emit_cnt  = (count_reg > CNT_W'(EMIT_MAX)) ? CNT_W'(EMIT_MAX) : count_reg;
    assign emit_last = ((CNT_W'(emit_idx_reg) + CNT_W'(1)) == emit_cnt);
    assign rank_sel  = rank_reg[emit_idx_reg];
    assign slot_sel  = (en_reg && (32'(rank_sel) < 32'(SLOTS))) ? SLOT_W'(rank_sel)
                                                                : SLOT_NONE;

    assign status.full      = (count_reg == CNT_W'(MAX_LIGHTS));
    assign status.emit_last = emit_last;
    assign status.out_free  = !m_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vx_reg <= '0;
            vy_reg <= '0;
            vz_reg <= '0;
            en_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_VIEWER_X: vx_reg <= cfg_data;
                REG_VIEWER_Y: vy_reg <= cfg_data;
                REG_VIEWER_Z: vz_reg <= cfg_data;
                REG_SLOTS_EN: en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Axis differences against the viewer as it stands on arrival
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            dx_reg <= abs_diff(in_data[COORD_W-1:0], vx_reg);
            dy_reg <= abs_diff(in_data[2*COORD_W-1:COORD_W], vy_reg);
            dz_reg <= abs_diff(in_data[3*COORD_W-1:2*COORD_W], vz_reg);
        end
        if (cmd.square) begin
            acc_reg <= acc_next;
        end
    end

    // Cell payload: distances and running ranks
    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            for (int k = 0; k < MAX_LIGHTS; k++) begin
                if (cell_valid[k] && cell_less[k]) begin
                    rank_reg[k] <= rank_reg[k] + IDX_W'(1);
                end
            end
            dist_reg[wr_idx] <= acc_reg;
            rank_reg[wr_idx] <= new_rank;
        end
    end

    // Batch control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_idx_reg <= '0;
        end else if (cmd.clear_batch) begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            emit_idx_reg <= '0;
        end else begin
            if (cmd.insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.set_ovf) begin
                ovf_reg <= 1'b1;
            end
            if (cmd.emit_load) begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            m_index_reg <= INDEX_W'(emit_idx_reg);
            m_slot_reg  <= slot_sel;
            m_ovf_reg   <= ovf_reg;
            m_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_slot_reg, m_index_reg});
    assign m_tuser  = m_ovf_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// File: hw/rtl/nearest_k_slot_assigner.sv
// A stored point passes accept, three multiplier steps on the shared squarer
// and one rank-cell insert; a dropped overflow point is only accepted.
// Batch end: from the insert the emit state loads the single output register,
// one result per cycle per stored point while the output is taken.
// Reset (aresetn low, synchronous) empties the batch, clears the overflow flag,
// sets the viewer to 0 and enables slots; distance cells are not cleared.
// ----------------------------------------------------------------------------
// nearest_k_slot_assigner
// Ranks a batch of points by squared distance to the viewer and gives the
// nearest SLOTS points slots 0 upward while slots are enabled, all others none.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_k_slot_assigner
    import nksa_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input points
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_W-1:0]       s_tdata,   // point_x, point_y, point_z
    input  wire logic                  s_tlast,   // batch_end
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_W-1:0]           m_tdata,   // point_index, slot, zero pad
    output logic                       m_tuser,   // overflowed
    output logic                       m_tlast,   // final_result
    // configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    nksa_cmd_t    cmd;
    nksa_status_t status;

    // registers take a write in any cycle
    assign cfg_ready = 1'b1;

    nksa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_last  (s_tlast),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    nksa_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// File: hw/rtl/nksa_checker.sv
// ----------------------------------------------------------------------------
// nksa_checker
// Port-level checks of the slot assigner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nearest_k_slot_assigner_macros.svh"

module nksa_checker
    import nksa_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_tvalid,
    input wire logic             s_tready,
    input wire logic             s_tlast,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic             m_tuser,
    input wire logic             m_tlast
);

    // whole result payload and its slot field
    logic [OUT_W+1:0]  m_word;
    logic [SLOT_W-1:0] m_slot;

    assign m_word = {m_tlast, m_tuser, m_tdata};
    assign m_slot = m_tdata[INDEX_W +: SLOT_W];

    // a stalled result holds its payload
    `NKSA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_word))

    // slot is a valid rank or the none code
    `NKSA_ASSERT_IMP(a_slot_code, m_tvalid, (m_slot < SLOT_W'(SLOTS)) || (m_slot == SLOT_NONE))

    // inputs stay blocked while a batch is still being emitted
    `NKSA_ASSERT_IMP(a_busy_emit, m_tvalid && !m_tlast, !s_tready)

    // a batch end never lets the next point in on the following cycle
    `NKSA_ASSERT_NXT(a_end_busy, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind nearest_k_slot_assigner nksa_checker u_nksa_checker (.*);

`default_nettype wire

// File: bench/nksa_slot_checker.sv
// ----------------------------------------------------------------------------
// nksa_slot_checker
// Watches the point, result and register channels of the slot assigner,
// keeps its own ranking of every batch and checks each result transaction
// against the oldest expected slot assignment.
// ----------------------------------------------------------------------------
module nksa_slot_checker
    import nksa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // point_x, point_y, point_z
    input  logic                  s_tlast,   // batch_end
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_W-1:0]      m_tdata,   // point_index, slot, zero pad
    input  logic                  m_tuser,   // overflowed
    input  logic                  m_tlast,   // final_result
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    slots_outstanding,
    output int                    results_checked
);

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [SLOT_W-1:0]  slot;
        logic               ovf;
        logic               last;
    } slot_result_t;

    // Shadow registers and batch state
    logic signed [COORD_W-1:0] view_x;
    logic signed [COORD_W-1:0] view_y;
    logic signed [COORD_W-1:0] view_z;
    logic                      slots_on;
    logic [DIST_W-1:0]         dist_mem [MAX_LIGHTS];
    int                        points_held;
    logic                      batch_ovf;
    slot_result_t              expected_slots [$];

    // Exact square of one coordinate difference
    function automatic logic [DIST_W-1:0] axis_sq(logic signed [COORD_W-1:0] p,
                                                  logic signed [COORD_W-1:0] v);
        logic signed [COORD_W:0] diff;
        logic [COORD_W-1:0]      mag;
        logic [DIST_W-1:0]       wide;
        diff = p - v;
        mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
        wide = DIST_W'(mag);
        return wide * wide;
    endfunction

    // Rank the held points and queue one result per point, arrival order
    function automatic void rank_batch();
        int                 i;
        int                 j;
        int                 rank;
        slot_result_t       r;
        for (i = 0; i < points_held; i++) begin
            rank = 0;
            for (j = 0; j < points_held; j++) begin
                if (dist_mem[j] < dist_mem[i] || (dist_mem[j] == dist_mem[i] && j < i))
                    rank++;
            end
            r.index = i[INDEX_W-1:0];
            r.slot  = (slots_on && rank < SLOTS) ? rank[SLOT_W-1:0] : SLOT_NONE;
            r.ovf   = batch_ovf;
            r.last  = (i == points_held - 1);
            expected_slots.insert(expected_slots.size(), r);
        end
    endfunction

    // One field compare, reported on mismatch
    function automatic void check_field(string field, logic [INDEX_W-1:0] want,
                                        logic [INDEX_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: result %s mismatch: expected %0h, got %0h",
                     $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        slot_result_t want;
        if (!aresetn) begin
            view_x      = '0;
            view_y      = '0;
            view_z      = '0;
            slots_on    = 1'b1;
            points_held = 0;
            batch_ovf   = 1'b0;
            expected_slots.delete();
            mismatch_count    = 0;
            results_checked   = 0;
        end else begin
            // register write transaction
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_VIEWER_X: view_x = cfg_data;
                    REG_VIEWER_Y: view_y = cfg_data;
                    REG_VIEWER_Z: view_z = cfg_data;
                    REG_SLOTS_EN: slots_on = cfg_data[0];
                    default: ;
                endcase
            end
            // point transaction: store distance or mark overflow
            if (s_tvalid && s_tready) begin
                if (points_held < MAX_LIGHTS) begin
                    dist_mem[points_held] = axis_sq(s_tdata[0 +: COORD_W], view_x)
                                          + axis_sq(s_tdata[COORD_W +: COORD_W], view_y)
                                          + axis_sq(s_tdata[2*COORD_W +: COORD_W], view_z);
                    points_held++;
                end else begin
                    batch_ovf = 1'b1;
                end
                if (s_tlast) begin
                    rank_batch();
                    points_held = 0;
                    batch_ovf   = 1'b0;
                end
            end
            // result transaction
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_slots.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result: expected none, got tdata %0h",
                             $time, m_tdata);
                end else begin
                    want = expected_slots.pop_front();
                    check_field("point_index", want.index, m_tdata[0 +: INDEX_W]);
                    check_field("slot", INDEX_W'(want.slot),
                                INDEX_W'(m_tdata[INDEX_W +: SLOT_W]));
                    check_field("overflowed", INDEX_W'(want.ovf), INDEX_W'(m_tuser));
                    check_field("final_result", INDEX_W'(want.last), INDEX_W'(m_tlast));
                end
            end
        end
        slots_outstanding = expected_slots.size();
    end

endmodule

// File: bench/tb_nearest_k_slot_assigner.sv
// ----------------------------------------------------------------------------
// tb_nearest_k_slot_assigner
// Drives batches of points and register settings into the slot assigner,
// with random gaps and result back-pressure, and reports the verdict from
// the slot checker.
// ----------------------------------------------------------------------------
module tb_nearest_k_slot_assigner;
    import nksa_pkg::*;

    localparam int ITEM_TARGET    = 330;
    localparam int IDLE_PCT       = 22;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sd32767;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;    // point_x, point_y, point_z
    logic                  s_tlast   = 1'b0;  // batch_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;           // point_index, slot, zero pad
    logic                  m_tuser;           // overflowed
    logic                  m_tlast;           // final_result
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int slots_outstanding;
    int results_checked;

    // Stimulus bookkeeping
    bit                        steady     = 1'b0;
    bit                        hold_asked = 1'b0;
    bit                        slots_live = 1'b1;
    logic signed [COORD_W-1:0] viewer_pos [3];
    int                        points_sent      = 0;
    int                        batches_sent     = 0;
    int                        overflow_batches = 0;
    int                        dark_batches     = 0;
    int                        quiet_cycles     = 0;

    nearest_k_slot_assigner uut (.*);

    nksa_slot_checker checker_i (.*);

    always #5 aclk = ~aclk;

    // Watchdog on cycles with no transaction on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("nearest_k_slot_assigner regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_asked && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Viewer position and slot enable; upper bits of the enable word are noise
    task automatic program_viewer(logic signed [COORD_W-1:0] vx,
                                  logic signed [COORD_W-1:0] vy,
                                  logic signed [COORD_W-1:0] vz, bit en);
        logic [CFG_DATA_W-1:0] en_word;
        en_word = {(CFG_DATA_W-1)'($urandom()), en};
        write_reg(REG_VIEWER_X, vx);
        write_reg(REG_VIEWER_Y, vy);
        write_reg(REG_VIEWER_Z, vz);
        write_reg(REG_SLOTS_EN, en_word);
        viewer_pos[0] = vx;
        viewer_pos[1] = vy;
        viewer_pos[2] = vz;
        slots_live    = en;
    endtask

    // One point transaction, with an optional gap ahead of it
    task automatic send_point(logic signed [COORD_W-1:0] px,
                              logic signed [COORD_W-1:0] py,
                              logic signed [COORD_W-1:0] pz, bit last);
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        points_sent++;
    endtask

    // Extremes, points near the viewer (ties and near ranks), or anything
    function automatic logic signed [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] v);
        case ($urandom_range(9))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            3, 4, 5: return COORD_W'(v + $urandom_range(8) - 4);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Mostly ordinary sizes, some tiny, some past the store depth
    function automatic int pick_batch_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return $urandom_range(MAX_LIGHTS + 1, MAX_LIGHTS + 4);
        else if (roll < 20)
            return $urandom_range(1, 3);
        return $urandom_range(4, MAX_LIGHTS);
    endfunction

    task automatic send_batch(int n);
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        int                        k;
        px = '0;
        py = '0;
        pz = '0;
        for (k = 0; k < n; k++) begin
            // repeated points force distance ties
            if (k == 0 || $urandom_range(99) >= 15) begin
                px = pick_coord(viewer_pos[0]);
                py = pick_coord(viewer_pos[1]);
                pz = pick_coord(viewer_pos[2]);
            end
            send_point(px, py, pz, k == n - 1);
        end
        batches_sent++;
        if (n > MAX_LIGHTS)
            overflow_batches++;
        if (!slots_live)
            dark_batches++;
    endtask

    // Let the block go idle before the next register change
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (slots_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int phase;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Largest possible distance, single-point batch
        program_viewer(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        batches_sent++;
        wait_drained();

        // Equal distances go to the lower index; more points than slots
        program_viewer('0, '0, '0, 1'b1);
        send_point('0, '0, '0, 1'b0);
        send_point(16'sd1, '0, '0, 1'b0);
        send_point(-16'sd1, '0, '0, 1'b0);
        send_point('0, '0, '0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        send_point('0, 16'sd1, '0, 1'b1);
        batches_sent++;
        wait_drained();

        // Slots off, one point past the store depth
        program_viewer(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        send_batch(MAX_LIGHTS + 1);
        wait_drained();

        // Random phases, each with its own register setting
        phase = 0;
        while (points_sent < ITEM_TARGET) begin
            case (phase)
                0:       program_viewer(COORD_MIN, COORD_MAX, '0, 1'b1);
                1:       program_viewer(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
                default: program_viewer(COORD_W'($urandom()), COORD_W'($urandom()),
                                        COORD_W'($urandom()),
                                        $urandom_range(99) >= 20);
            endcase
            steady = (phase == 2);
            if (phase == 3)
                hold_asked = 1'b1;
            repeat ($urandom_range(3, 5)) send_batch(pick_batch_size());
            wait_drained();
            phase++;
        end
        steady = 1'b0;

        $display("covered %0d points in %0d batches: %0d past store depth, %0d with slots off",
                 points_sent, batches_sent, overflow_batches, dark_batches);
        $display("checked %0d slot results over %0d register settings",
                 results_checked, phase + 3);
        if (mismatch_count == 0 && slots_outstanding == 0) begin
            $display("nearest_k_slot_assigner regression: pass");
        end else begin
            $display("nearest_k_slot_assigner regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/nksa_pkg.sv
hw/rtl/nksa_ctrl.sv
hw/rtl/nksa_datapath.sv
hw/rtl/nearest_k_slot_assigner.sv
hw/rtl/nksa_checker.sv
bench/nksa_slot_checker.sv
bench/tb_nearest_k_slot_assigner.sv
